@@ src/downscale_2x2_box_average_unit_macros.svh @@
// Assertion macros for the checker file of the 2x2 box downscaler.
`ifndef DOWNSCALE_2X2_BOX_AVERAGE_UNIT_MACROS_SVH
`define DOWNSCALE_2X2_BOX_AVERAGE_UNIT_MACROS_SVH

// Check prop in the same cycle as cond.
`define DSBA_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("dsba: same-cycle implication failed");

// Check prop in the cycle after cond.
`define DSBA_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("dsba: next-cycle implication failed");

`endif

@@ src/dsba_pkg.sv @@
package dsba_pkg;

  localparam int PIXEL_W    = 8;
  localparam int PAIR_W     = 9;
  localparam int SUM_W      = 10;
  localparam int COLS_CFG_W = 12;
  localparam int ROWS_W     = 16;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_COLS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_ROWS = 1'b1;

  localparam int COLS_RESET = 640;
  localparam int ROWS_RESET = 480;

  localparam int DEFAULT_MAX_COLS = 2048;

  // Line store request controls: write enable and read enable.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } line_mem_ctrl_t;

endpackage

@@ src/dsba_line_mem.sv @@
module dsba_line_mem #(
  parameter int DEPTH = (dsba_pkg::DEFAULT_MAX_COLS + 1) / 2
) (
  input  logic                                clk,
  input  dsba_pkg::line_mem_ctrl_t            ctrl,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [dsba_pkg::PAIR_W-1:0]         wr_data,
  output logic [dsba_pkg::PAIR_W-1:0]         rd_data
);

  logic [dsba_pkg::PAIR_W-1:0] mem [DEPTH];
  logic [dsba_pkg::PAIR_W-1:0] rd_data_r;

  // One request a cycle; read data holds until the next read.
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/downscale_2x2_box_average_unit.sv @@
// 2x2 box downscaler: a result passes stage 1, then the output register.
// Throughput 1 pixel per cycle while in_stall is low; the single line store port is
// used once per odd column. in_stall rises during reset, or else only while a result
// is held at the output and another is in flight from the line store read.
// Synchronous active-low reset clears counters, sizes (640x480) and valids;
// the line store is not cleared and needs no clearing pass.
module downscale_2x2_box_average_unit #(
  parameter int MAX_COLS = dsba_pkg::DEFAULT_MAX_COLS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration write port
  input  logic                                 cfg_wr_en,
  input  logic [dsba_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [dsba_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
  // pixel input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [dsba_pkg::PIXEL_W-1:0]         in_pixel_in,
  // downscaled pixel output channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [dsba_pkg::PIXEL_W-1:0]         out_pixel_out,
  output logic                                 out_row_end,
  output logic                                 out_frame_end
);

  // Line store holds one pair sum per column pair.
  localparam int LINE_DEPTH = (MAX_COLS + 1) / 2;
  localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  // Column counter width; the size register gets one more bit to hold MAX_COLS.
  localparam int CW         = ($clog2(MAX_COLS) > 2) ? $clog2(MAX_COLS) : 2;
  localparam int CLAMP_W    = 16;
  localparam int COLS_RESET_EFF =
    (dsba_pkg::COLS_RESET > MAX_COLS) ? MAX_COLS : dsba_pkg::COLS_RESET;

  localparam int PW = dsba_pkg::PIXEL_W;
  localparam int QW = dsba_pkg::PAIR_W;
  localparam int SW = dsba_pkg::SUM_W;
  localparam int RW = dsba_pkg::ROWS_W;

  // Effective frame size, already clamped at write time.
  logic [CW:0]   cols_r, cols_nxt;
  logic [RW-1:0] rows_r, rows_nxt;
  logic [CLAMP_W-1:0] cols_wide;

  // Raster position and the pixel at the last even column.
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [PW-1:0] left_r, left_nxt;
  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc;

  // Stage 1: line store read in flight.
  logic          v1_r, v1_nxt;
  logic [QW-1:0] pair1_r;
  logic          re1_r, fe1_r;

  // Output register.
  logic          out_valid_r, out_valid_nxt;
  logic [PW-1:0] out_pixel_r;
  logic          out_row_end_r, out_frame_end_r;

  logic          accept;
  logic          in_frame;
  logic          s1_adv;
  logic [QW-1:0] pair;
  logic [CW:0]   last_col;
  logic [RW-1:0] last_row;
  logic          re, fe;
  logic [SW-1:0] block_sum;
  logic [SW-1:0] block_rnd;
  logic [QW-1:0] line_rd_data;
  logic [AW-1:0] line_addr;

  dsba_pkg::line_mem_ctrl_t line_ctrl;

  // Stage 1 moves on when the output register is empty or being taken.
  assign s1_adv   = !out_valid_r || !out_stall;
  // Hold input while a result is stuck in stage 1, and during reset.
  assign in_stall = !rst_n || (v1_r && !s1_adv);
  assign accept   = in_valid && !in_stall;

  assign in_frame = ({1'b0, col_r} < cols_r) && (row_r < rows_r);
  assign pair     = {1'b0, left_r} + {1'b0, in_pixel_in};

  // Last odd column and last odd row; a size of one never matches.
  assign last_col = {cols_r[CW:1], 1'b0} - {{CW{1'b0}}, 1'b1};
  assign last_row = {rows_r[RW-1:1], 1'b0} - {{(RW-1){1'b0}}, 1'b1};
  assign re       = ({1'b0, col_r} == last_col);
  assign fe       = re && (row_r == last_row);

  // Even rows store pair sums, odd rows read them back at odd columns.
  assign line_ctrl.wr_en = accept && in_frame && col_r[0] && !row_r[0];
  assign line_ctrl.rd_en = accept && in_frame && col_r[0] && row_r[0];
  assign line_addr       = col_r[AW:1];

  dsba_line_mem #(
    .DEPTH (LINE_DEPTH)
  ) u_line_mem (
    .clk     (clk),
    .ctrl    (line_ctrl),
    .addr    (line_addr),
    .wr_data (pair),
    .rd_data (line_rd_data)
  );

  // Size registers: clamp columns to 1..MAX_COLS and rows to at least 1.
  always_comb begin
    cols_nxt  = cols_r;
    rows_nxt  = rows_r;
    cols_wide = {{(CLAMP_W-dsba_pkg::COLS_CFG_W){1'b0}},
                 cfg_wr_data[dsba_pkg::COLS_CFG_W-1:0]};
    if (cfg_wr_en) begin
      unique case (cfg_index)
        dsba_pkg::REG_IMAGE_COLS: begin
          if (cols_wide == '0) begin
            cols_nxt = (CW+1)'(1);
          end else if (cols_wide > CLAMP_W'(MAX_COLS)) begin
            cols_nxt = (CW+1)'(MAX_COLS);
          end else begin
            cols_nxt = cols_wide[CW:0];
          end
        end
        dsba_pkg::REG_IMAGE_ROWS: begin
          rows_nxt = (cfg_wr_data[RW-1:0] == '0) ? RW'(1) : cfg_wr_data[RW-1:0];
        end
        default: begin
          cols_nxt = cols_r;
        end
      endcase
    end
  end

  // Raster counters: wrap column at the width, row at the height.
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    left_nxt = left_r;
    col_inc  = {1'b0, col_r} + {{CW{1'b0}}, 1'b1};
    row_inc  = {1'b0, row_r} + {{RW{1'b0}}, 1'b1};
    if (accept) begin
      if (in_frame && !col_r[0]) begin
        left_nxt = in_pixel_in;
      end
      if (col_inc >= cols_r) begin
        col_nxt = '0;
        row_nxt = (row_inc >= {1'b0, rows_r}) ? '0 : row_inc[RW-1:0];
      end else begin
        col_nxt = col_inc[CW-1:0];
        row_nxt = (row_r >= rows_r) ? '0 : row_r;
      end
    end
  end

  // Stage 1 and output valids.
  always_comb begin
    v1_nxt        = v1_r;
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = v1_r;
      v1_nxt        = 1'b0;
    end
    if (line_ctrl.rd_en) begin
      v1_nxt = 1'b1;
    end
  end

  // Rounded average of the stored pair and the current pair.
  assign block_sum = {1'b0, line_rd_data} + {1'b0, pair1_r};
  assign block_rnd = block_sum + SW'(2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r      <= (CW+1)'(COLS_RESET_EFF);
      rows_r      <= RW'(dsba_pkg::ROWS_RESET);
      col_r       <= '0;
      row_r       <= '0;
      left_r      <= '0;
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cols_r      <= cols_nxt;
      rows_r      <= rows_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      left_r      <= left_nxt;
      v1_r        <= v1_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: capture on read issue, load output when stage 1 advances.
  always_ff @(posedge clk) begin
    if (line_ctrl.rd_en) begin
      pair1_r <= pair;
      re1_r   <= re;
      fe1_r   <= fe;
    end
    if (s1_adv && v1_r) begin
      out_pixel_r     <= block_rnd[SW-1:2];
      out_row_end_r   <= re1_r;
      out_frame_end_r <= fe1_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;
  assign out_row_end   = out_row_end_r;
  assign out_frame_end = out_frame_end_r;

endmodule

@@ src/dsba_checker.sv @@
`include "downscale_2x2_box_average_unit_macros.svh"

module dsba_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [dsba_pkg::PIXEL_W-1:0]     out_pixel_out,
  input logic                             out_row_end,
  input logic                             out_frame_end
);

  // A stalled result stays offered and unchanged.
  `DSBA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_pixel_out) && $stable(out_row_end) && $stable(out_frame_end))

  // Frame end only on the last pixel of a row.
  `DSBA_ASSERT_IMPLY(a_frame_end_row_end, clk, rst_n, out_valid && out_frame_end, out_row_end)

  // Input is held back only while the output is stalled; reset holds it too.
  `DSBA_ASSERT_IMPLY(a_stall_cause, clk, rst_n, rst_n && in_stall, out_valid && out_stall)

  // A fresh result comes from an accepted request that passed through the stage 1 valid register.
  `DSBA_ASSERT_IMPLY(a_result_source, clk, rst_n, $rose(out_valid), $past(in_valid && !in_stall, 2))

endmodule

bind downscale_2x2_box_average_unit dsba_checker u_dsba_checker (.*);
